// ===== rtl/jtsm_pkg.sv =====
package jtsm_pkg;

   localparam int MAX_SCAN_BITS  = 64;
   localparam int RESET_TMS_ONES = 128;

   localparam int CMD_W       = 3;
   localparam int SCAN_LEN_W  = 7;
   localparam int DATA_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int PERIOD_W    = 16;
   localparam int STEP_W      = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [STEP_W-1:0] RESET_HDR_LEN = STEP_W'(RESET_TMS_ONES);
   localparam logic [STEP_W-1:0] IR_HDR_LEN    = STEP_W'(4);
   localparam logic [STEP_W-1:0] DR_HDR_LEN    = STEP_W'(3);

   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TAP_RESET = 3'd1;
   localparam logic [CMD_W-1:0] CMD_IR_SCAN   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DR_SCAN   = 3'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY        = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_PERIOD_ADDR = 2'd0;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic                  capture;
      logic [SCAN_LEN_W-1:0] scan_length;
      logic [DATA_W-1:0]     write_data;
      logic                  tdo;
   } req_type;

   typedef struct packed {
      logic                tck;
      logic                tms;
      logic                tdi;
      logic                busy_res;
      logic                done_res;
      logic [DATA_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ===== rtl/jtsm_csr.sv =====
module jtsm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jtsm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [jtsm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [jtsm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [jtsm_pkg::PERIOD_W-1:0]     half_period
);
   import jtsm_pkg::*;

   logic [PERIOD_W-1:0] half_period_ff;
   logic [PERIOD_W-1:0] half_period_in;
   logic                wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_HALF_PERIOD_ADDR);

   always_comb begin
      half_period_in = half_period_ff;
      if (wr_hit) begin
         half_period_in = csr_pwdata[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= '0;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_HALF_PERIOD_ADDR) begin
         csr_prdata = CSR_DATA_W'(half_period_ff);
      end
   end

   assign half_period = half_period_ff;

endmodule

// ===== rtl/jtsm_engine.sv =====
module jtsm_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  jtsm_pkg::req_type             req,
   input  logic [jtsm_pkg::PERIOD_W-1:0] half_period,
   output jtsm_pkg::rsp_type             result
);
   import jtsm_pkg::*;

   typedef enum logic [2:0] {
      KIND_IDLE,
      KIND_RESET,
      KIND_IR_W,
      KIND_IR_R,
      KIND_DR_W,
      KIND_DR_R
   } kind_type;

   kind_type              kind_ff, kind_in;
   logic [PERIOD_W-1:0]   phase_timer_ff, phase_timer_in;
   logic                  tck_ff, tck_in;
   logic                  tms_ff, tms_in;
   logic                  tdi_ff, tdi_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SCAN_LEN_W-1:0] bit_index_ff, bit_index_in;
   logic [SCAN_LEN_W-1:0] scan_bits_ff, scan_bits_in;
   logic [DATA_W-1:0]     shift_out_ff, shift_out_in;
   logic [DATA_W-1:0]     shift_in_ff, shift_in_in;

   logic [STEP_W-1:0]     hdr_len;
   logic                  is_read;
   logic                  is_ir;
   logic [STEP_W-1:0]     step_nx;
   logic [SCAN_LEN_W-1:0] bit_nx;
   logic                  done;
   logic [STATUS_W-1:0]   status;

   assign is_read = (kind_ff == KIND_IR_R) || (kind_ff == KIND_DR_R);
   assign is_ir   = (kind_ff == KIND_IR_W) || (kind_ff == KIND_IR_R);

   always_comb begin
      case (kind_ff)
         KIND_RESET: hdr_len = RESET_HDR_LEN;
         KIND_IR_W,
         KIND_IR_R:  hdr_len = IR_HDR_LEN;
         default:    hdr_len = DR_HDR_LEN;
      endcase
   end

   always_comb begin
      kind_in        = kind_ff;
      phase_timer_in = phase_timer_ff;
      tck_in         = tck_ff;
      tms_in         = tms_ff;
      tdi_in         = tdi_ff;
      step_in        = step_ff;
      bit_index_in   = bit_index_ff;
      scan_bits_in   = scan_bits_ff;
      shift_out_in   = shift_out_ff;
      shift_in_in    = shift_in_ff;
      step_nx        = step_ff;
      bit_nx         = bit_index_ff;
      done           = 1'b0;
      status         = STATUS_OK;
      if (accept) begin
         if (req.cmd > CMD_DR_SCAN) begin
            status = STATUS_UNSUPPORTED;
         end else if (req.cmd != CMD_TICK && kind_ff != KIND_IDLE) begin
            status = STATUS_BUSY;
         end else if (kind_ff != KIND_IDLE) begin
            if (phase_timer_ff < half_period) begin
               phase_timer_in = phase_timer_ff + 1'b1;
            end else begin
               phase_timer_in = '0;
               if (tck_ff) begin
                  if (is_read && step_ff >= hdr_len && bit_index_ff < scan_bits_ff) begin
                     shift_in_in[bit_index_ff[5:0]] = req.tdo;
                  end
                  tck_in = 1'b0;
               end else begin
                  if (step_ff < hdr_len) begin
                     step_nx = step_ff + 1'b1;
                  end else begin
                     bit_nx = bit_index_ff + 1'b1;
                  end
                  step_in      = step_nx;
                  bit_index_in = bit_nx;
                  if (step_nx >= hdr_len &&
                      {1'b0, bit_nx} >= ({1'b0, scan_bits_ff} + 8'd2)) begin
                     kind_in = KIND_IDLE;
                     done    = 1'b1;
                  end else begin
                     tck_in = 1'b1;
                     if (step_nx < hdr_len) begin
                        if (kind_ff == KIND_RESET) begin
                           tms_in = 1'b1;
                        end else if (is_ir) begin
                           tms_in = (step_nx < 8'd2);
                        end else begin
                           tms_in = (step_nx == '0);
                        end
                     end else if (kind_ff == KIND_RESET) begin
                        tms_in = 1'b0;
                     end else begin
                        if (is_read) begin
                           tdi_in = 1'b0;
                        end
                        if (bit_nx < scan_bits_ff) begin
                           tms_in = (SCAN_LEN_W'(bit_nx + 7'd1) == scan_bits_ff);
                           if (!is_read) begin
                              tdi_in       = shift_out_ff[0];
                              shift_out_in = shift_out_ff >> 1;
                           end
                        end else begin
                           tms_in = (bit_nx == scan_bits_ff);
                        end
                     end
                  end
               end
            end
         end else if (req.cmd != CMD_TICK) begin
            case (req.cmd)
               CMD_TAP_RESET: begin
                  kind_in      = KIND_RESET;
                  scan_bits_in = '0;
               end
               CMD_IR_SCAN: begin
                  kind_in = req.capture ? KIND_IR_R : KIND_IR_W;
               end
               default: begin
                  kind_in = req.capture ? KIND_DR_R : KIND_DR_W;
               end
            endcase
            if (req.cmd != CMD_TAP_RESET) begin
               scan_bits_in = (req.scan_length > SCAN_LEN_W'(MAX_SCAN_BITS)) ?
                              SCAN_LEN_W'(MAX_SCAN_BITS) : req.scan_length;
            end
            shift_out_in   = (req.cmd == CMD_TAP_RESET) ? '0 : req.write_data;
            shift_in_in    = '0;
            step_in        = '0;
            bit_index_in   = '0;
            phase_timer_in = '0;
            tms_in         = 1'b1;
            tck_in         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff        <= KIND_IDLE;
         phase_timer_ff <= '0;
         tck_ff         <= 1'b0;
         tms_ff         <= 1'b0;
         tdi_ff         <= 1'b0;
         step_ff        <= '0;
         bit_index_ff   <= '0;
         scan_bits_ff   <= '0;
         shift_out_ff   <= '0;
         shift_in_ff    <= '0;
      end else begin
         kind_ff        <= kind_in;
         phase_timer_ff <= phase_timer_in;
         tck_ff         <= tck_in;
         tms_ff         <= tms_in;
         tdi_ff         <= tdi_in;
         step_ff        <= step_in;
         bit_index_ff   <= bit_index_in;
         scan_bits_ff   <= scan_bits_in;
         shift_out_ff   <= shift_out_in;
         shift_in_ff    <= shift_in_in;
      end
   end

   always_comb begin
      result.tck       = tck_in;
      result.tms       = tms_in;
      result.tdi       = tdi_in;
      result.busy_res  = (kind_in != KIND_IDLE);
      result.done_res  = done;
      result.read_data = shift_in_in;
      result.status    = status;
   end

endmodule

// ===== rtl/jtsm_out.sv =====
module jtsm_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  jtsm_pkg::rsp_type result,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output jtsm_pkg::rsp_type rsp_data,
   output logic              full_stall
);
   import jtsm_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign full_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/jtag_tap_scan_master_top.sv =====
// JTAG scan master clocked by tick transactions: each req transaction is one
// tick of the TCK divider and yields exactly one rsp transaction with the pin
// levels, busy/done flags, captured TDO bits and command status. A transaction
// is taken every clock cycle while the result register is empty or draining;
// its result appears next cycle. Each TCK phase spans half_period_ticks+1
// tick transactions; half_period_ticks sits at csr byte address 0 (bits 15:0).
// Commands: 1 TAP reset (128 TMS ones, then two zeros), 2 IR scan, 3 DR scan,
// each of up to 64 bits, LSB first; TDO is sampled on the tick TCK falls.
module jtag_tap_scan_master_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  jtsm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output jtsm_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [jtsm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [jtsm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [jtsm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import jtsm_pkg::*;

   logic [PERIOD_W-1:0] half_period;
   logic                accept;
   logic                full_stall;
   rsp_type             result;

   assign req_stall = full_stall;
   assign accept    = req_valid && !full_stall;

   jtsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .half_period (half_period)
   );

   jtsm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .half_period (half_period),
      .result      (result)
   );

   jtsm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .full_stall (full_stall)
   );

endmodule
